FILE: src/ild_pkg.sv
// shared types and constants of the irc line deframer
// depends on nothing; used by ild_decode, ild_result_fifo and irc_line_deframer
package ild_pkg;

    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_COLON = 8'h3A;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int LEVEL_W    = 3;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       line_end;
    } ild_word_t;

    // what one input byte produces: zero, one or two words
    typedef struct packed {
        logic [1:0] count;
        ild_word_t  w0;
        ild_word_t  w1;
    } ild_step_t;

endpackage

FILE: src/irc_line_deframer.sv
// top level of the irc line deframer: input byte register, decoder, result queue
// depends on ild_pkg, ild_decode and ild_result_fifo
//
// channel   dir  tdata          tuser      tlast
// s_axis    in   in_byte[7:0]   -          -
// m_axis    out  out_byte[7:0]  has_byte   line_end
//
// one byte per cycle if the queue has room; input register and 4-word result queue
// a held cr released ahead of the next byte makes two words for that one byte;
// the queue absorbs them, and input stalls only when it lacks room for two
// reset (async, active low) empties the queue and returns to skipping between lines
// input ready depends only on registers: free input register or queue room for two
module irc_line_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] has_byte
    output logic       m_tlast
);

    logic [7:0]                     in_byte_reg;
    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic                           room;
    logic                           step_en;
    logic [ild_pkg::LEVEL_W-1:0]    level;
    ild_pkg::ild_step_t             step;
    ild_pkg::ild_word_t             head_word;

    assign step_en  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    ild_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .in_byte (in_byte_reg),
        .step    (step)
    );

    ild_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (step_en),
        .wr_step   (step),
        .room      (room),
        .level     (level),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head_word (head_word)
    );

    assign m_tdata = head_word.out_byte;
    assign m_tuser = head_word.has_byte;
    assign m_tlast = head_word.line_end;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ild_pkg::LEVEL_W'(ild_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_pair_leads_cr: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && step.count == 2'd2) |->
        (step.w0.has_byte && step.w0.out_byte == ild_pkg::CHR_CR))
        else $error("two-word step without released cr");

    a_word_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != m_tlast))
        else $error("output word neither byte nor line end");

    a_step_clears_input: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !s_tvalid) |=> !in_valid_reg)
        else $error("input register not released after step");
`endif

endmodule

FILE: src/ild_decode.sv
// line framing state machine: phase, held cr and the words caused by one byte
// depends on ild_pkg
module ild_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        in_byte,
    output ild_pkg::ild_step_t step
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_PREFIX,
        PH_PSPACE,
        PH_BODY
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   cr_pending_reg;
    logic   cr_pending_next;

    ild_pkg::ild_word_t byte_word;
    ild_pkg::ild_word_t cr_word;
    ild_pkg::ild_word_t end_word;
    ild_pkg::ild_word_t body_word;
    logic               is_lf;
    logic               is_cr;
    logic               is_sp;

    always_comb
    begin
        is_lf = (in_byte == ild_pkg::CHR_LF);
        is_cr = (in_byte == ild_pkg::CHR_CR);
        is_sp = (in_byte == ild_pkg::CHR_SP);

        byte_word = '{out_byte: in_byte, has_byte: 1'b1, line_end: 1'b0};
        cr_word   = '{out_byte: ild_pkg::CHR_CR, has_byte: 1'b1, line_end: 1'b0};
        end_word  = '{out_byte: 8'h00, has_byte: 1'b0, line_end: 1'b1};
        // body handling: lf closes the line, any other non-cr byte passes
        body_word = is_lf ? end_word : byte_word;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        cr_pending_next = cr_pending_reg;
        step            = '0;

        case (phase_reg)
            PH_PREFIX:
            begin
                cr_pending_next = 1'b0;
                if (is_sp)
                begin
                    phase_next = PH_PSPACE;
                end
                else if (is_lf)
                begin
                    step.w0    = end_word;
                    step.count = 2'd1;
                    phase_next = PH_SKIP;
                end
            end
            PH_PSPACE:
            begin
                cr_pending_next = 1'b0;
                if (!is_sp)
                begin
                    phase_next = is_lf ? PH_SKIP : PH_BODY;
                    if (is_cr)
                    begin
                        cr_pending_next = 1'b1;
                    end
                    else
                    begin
                        step.w0    = body_word;
                        step.count = 2'd1;
                    end
                end
            end
            PH_BODY:
            begin
                if (cr_pending_reg && is_lf)
                begin
                    // cr lf: the held cr is dropped
                    cr_pending_next = 1'b0;
                    step.w0         = end_word;
                    step.count      = 2'd1;
                    phase_next      = PH_SKIP;
                end
                else if (cr_pending_reg)
                begin
                    // release the held cr ahead of this byte
                    step.w0 = cr_word;
                    if (is_cr)
                    begin
                        cr_pending_next = 1'b1;
                        step.count      = 2'd1;
                    end
                    else
                    begin
                        cr_pending_next = 1'b0;
                        step.w1         = byte_word;
                        step.count      = 2'd2;
                    end
                end
                else if (is_cr)
                begin
                    cr_pending_next = 1'b1;
                end
                else
                begin
                    step.w0    = body_word;
                    step.count = 2'd1;
                    if (is_lf)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            default:
            begin
                if (cr_pending_reg && is_lf)
                begin
                    cr_pending_next = 1'b0;
                end
                else if (cr_pending_reg)
                begin
                    // lone cr starts a line
                    step.w0    = cr_word;
                    phase_next = PH_BODY;
                    if (is_cr)
                    begin
                        cr_pending_next = 1'b1;
                        step.count      = 2'd1;
                    end
                    else
                    begin
                        cr_pending_next = 1'b0;
                        step.w1         = byte_word;
                        step.count      = 2'd2;
                    end
                end
                else if (is_sp || is_lf)
                begin
                    phase_next = PH_SKIP;
                end
                else if (is_cr)
                begin
                    cr_pending_next = 1'b1;
                end
                else if (in_byte == ild_pkg::CHR_COLON)
                begin
                    phase_next = PH_PREFIX;
                end
                else
                begin
                    step.w0    = byte_word;
                    step.count = 2'd1;
                    phase_next = PH_BODY;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SKIP;
            cr_pending_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            cr_pending_reg <= cr_pending_next;
        end
    end

endmodule

FILE: src/ild_result_fifo.sv
// result queue: takes zero to two words per cycle, gives one per ready cycle
// depends on ild_pkg
module ild_result_fifo
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  ild_pkg::ild_step_t               wr_step,
    output logic                             room,
    output logic [ild_pkg::LEVEL_W-1:0]      level,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output ild_pkg::ild_word_t               head_word
);

    ild_pkg::ild_word_t                 mem_reg [ild_pkg::FIFO_DEPTH];
    logic [ild_pkg::PTR_W-1:0]          wr_ptr_reg;
    logic [ild_pkg::PTR_W-1:0]          wr_ptr_next;
    logic [ild_pkg::PTR_W-1:0]          rd_ptr_reg;
    logic [ild_pkg::PTR_W-1:0]          rd_ptr_next;
    logic [ild_pkg::LEVEL_W-1:0]        level_reg;
    logic [ild_pkg::LEVEL_W-1:0]        level_next;
    logic [ild_pkg::LEVEL_W-1:0]        wr_cnt;
    logic                               rd_en;

    always_comb
    begin
        wr_cnt      = wr_en ? {{(ild_pkg::LEVEL_W-2){1'b0}}, wr_step.count}
                            : '0;
        rd_en       = m_tvalid && m_tready;
        wr_ptr_next = wr_ptr_reg + wr_cnt[ild_pkg::PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + ild_pkg::PTR_W'(rd_en);
        level_next  = level_reg + wr_cnt - ild_pkg::LEVEL_W'(rd_en);
    end

    // room for a worst-case two-word step
    assign room      = (level_reg <= ild_pkg::LEVEL_W'(ild_pkg::FIFO_DEPTH - 2));
    assign level     = level_reg;
    assign m_tvalid  = (level_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_step.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr_step.w0;
        end
        if (wr_en && wr_step.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + ild_pkg::PTR_W'(1)] <= wr_step.w1;
        end
    end

endmodule
